/* src/as_pkg.sv */
// as_pkg: shared types and constants for the array_sorter block
// key, request and result structs, state encoding and cell control
// no dependencies
package as_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int KEY_W        = 32;

  typedef logic signed [KEY_W-1:0] key_t;

  typedef struct packed {
    key_t key;
    logic set_end;
  } in_t;

  typedef struct packed {
    key_t sorted_key;
    logic final_res;
    logic overflowed;
  } out_t;

  typedef enum logic {
    ST_COLLECT,
    ST_DRAIN
  } state_t;

  // control broadcast to every cell of the chain
  typedef struct packed {
    logic insert;
    logic shift_out;
  } cell_ctl_t;

endpackage

/* src/as_cell.sv */
// as_cell: one slot of the insertion sort chain
// holds one key and its valid bit, inserts or shifts toward cell 0
// depends on as_pkg
module as_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  as_pkg::cell_ctl_t ctl,
  input  as_pkg::key_t      new_key,
  input  logic              prev_lt,
  input  as_pkg::key_t      prev_key,
  input  logic              prev_valid,
  input  as_pkg::key_t      next_key,
  input  logic              next_valid,
  output logic              lt,
  output as_pkg::key_t      key,
  output logic              valid
);
  import as_pkg::*;

  key_t key_r, key_nxt;
  logic valid_r, valid_nxt;

  // new key goes before this entry (an empty slot counts as larger)
  assign lt = !valid_r || (new_key < key_r);

  always_comb begin
    key_nxt   = key_r;
    valid_nxt = valid_r;
    if (ctl.shift_out) begin
      key_nxt   = next_key;
      valid_nxt = next_valid;
    end else if (ctl.insert && lt) begin
      // left neighbor also moves right: take its entry, else the new key lands here
      if (prev_lt) begin
        key_nxt   = prev_key;
        valid_nxt = prev_valid;
      end else begin
        key_nxt   = new_key;
        valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

  assign key   = key_r;
  assign valid = valid_r;

endmodule

/* src/array_sorter.sv */
// array_sorter: collects a set of signed keys and returns them in ascending order
// top level, a chain of as_cell slots plus request/result control
// depends on as_pkg and as_cell
//
// Usage: keys arrive on the in_ channel, one request per cycle while in_ready is
// high, each with a set_end flag on the last key of the set. Each accepted key
// is placed in sorted position in the cell chain in the same cycle it is taken. Up to
// CAPACITY keys are held; later keys of the set are dropped and every result
// of that set carries overflowed = 1.
// After the set_end key is accepted the chain drains through cell 0, one
// result per cycle into the output register while it can take one; the first
// result is loaded once the state register has entered ST_DRAIN. A set of N
// stored keys gives N results; final_res marks the last one. While draining
// in_ready is low; it rises as soon as the last result is in the output
// register, so the next set can start while that result still waits.
// When out_ready is low the drain pauses and the chain holds its contents.
// Reset (rst_n low, synchronous) clears the cell valid bits, the overflow
// flag and the output register valid; no clearing pass is needed.
module array_sorter #(
  parameter int CAPACITY = as_pkg::CAPACITY_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  as_pkg::in_t  in_data,
  output logic         out_valid,
  input  logic         out_ready,
  output as_pkg::out_t out_data
);
  import as_pkg::*;

  state_t    state_r, state_nxt;
  cell_ctl_t ctl;
  logic      ovf_r, ovf_nxt;
  logic      out_valid_r, out_valid_nxt;
  out_t      out_r, out_nxt;
  logic      load;
  logic      full;
  logic      accept;

  key_t                cell_key [CAPACITY];
  logic [CAPACITY-1:0] cell_vld;
  logic [CAPACITY-1:0] cell_lt;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic prev_lt_w;
    key_t prev_key_w;
    logic prev_vld_w;
    key_t next_key_w;
    logic next_vld_w;

    if (i == 0) begin : g_first
      assign prev_lt_w  = 1'b0;
      assign prev_key_w = in_data.key;
      assign prev_vld_w = 1'b0;
    end else begin : g_mid
      assign prev_lt_w  = cell_lt[i-1];
      assign prev_key_w = cell_key[i-1];
      assign prev_vld_w = cell_vld[i-1];
    end

    if (i == CAPACITY-1) begin : g_last
      assign next_key_w = cell_key[i];
      assign next_vld_w = 1'b0;
    end else begin : g_inner
      assign next_key_w = cell_key[i+1];
      assign next_vld_w = cell_vld[i+1];
    end

    as_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .new_key    (in_data.key),
      .prev_lt    (prev_lt_w),
      .prev_key   (prev_key_w),
      .prev_valid (prev_vld_w),
      .next_key   (next_key_w),
      .next_valid (next_vld_w),
      .lt         (cell_lt[i]),
      .key        (cell_key[i]),
      .valid      (cell_vld[i])
    );
  end

  assign full   = cell_vld[CAPACITY-1];
  assign accept = in_valid && in_ready;
  assign load   = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    in_ready      = 1'b0;
    ctl           = '0;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    unique case (state_r)
      ST_COLLECT: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (full) begin
            ovf_nxt = 1'b1;
          end else begin
            ctl.insert = 1'b1;
          end
          if (in_data.set_end) begin
            state_nxt = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (load) begin
          ctl.shift_out          = 1'b1;
          out_valid_nxt          = 1'b1;
          out_nxt.sorted_key     = cell_key[0];
          out_nxt.final_res      = !cell_vld[1];
          out_nxt.overflowed     = ovf_r;
          if (!cell_vld[1]) begin
            state_nxt = ST_COLLECT;
            ovf_nxt   = 1'b0;
          end
        end
      end
      default: state_nxt = ST_COLLECT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_COLLECT;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // adjacent occupied cells stay in ascending order
  logic order_ok;
  always_comb begin
    order_ok = 1'b1;
    for (int i = 0; i < CAPACITY-1; i++) begin
      if (cell_vld[i+1] && (cell_key[i] > cell_key[i+1])) begin
        order_ok = 1'b0;
      end
    end
  end

  a_vld_packed: assert property (@(posedge clk) disable iff (!rst_n)
    (cell_vld & (cell_vld + 1'b1)) == '0)
    else $error("cell valid bits not packed toward cell 0");

  a_order: assert property (@(posedge clk) disable iff (!rst_n) order_ok)
    else $error("cell chain out of order");

  a_drain_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DRAIN |-> cell_vld[0])
    else $error("drain with empty chain");

  a_set_end_drain: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_data.set_end |=> state_r == ST_DRAIN)
    else $error("set end did not start drain");

endmodule
